// ===== rtl/core/telnet_receive_parser_core_defines.svh =====
// ----------------------------------------------------------------------------
// telnet receive parser core - assertion macros
// shared property wrappers for the core's internal checks
// ----------------------------------------------------------------------------
`ifndef TELNET_RECEIVE_PARSER_CORE_DEFINES_SVH
`define TELNET_RECEIVE_PARSER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define TRP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("telnet parser check failed");

// next-cycle implication, disabled while reset is high
`define TRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("telnet parser sequence check failed");

`endif

// ===== rtl/core/trp_pkg.sv =====
// ----------------------------------------------------------------------------
// trp_pkg
// constants, command codes and the front-to-back command type
// ----------------------------------------------------------------------------
`default_nettype none

package trp_pkg;

   // telnet protocol bytes
   localparam logic [7:0] IAC           = 8'd255;
   localparam logic [7:0] DONT          = 8'd254;
   localparam logic [7:0] DO            = 8'd253;
   localparam logic [7:0] WONT          = 8'd252;
   localparam logic [7:0] WILL          = 8'd251;
   localparam logic [7:0] SB            = 8'd250;
   localparam logic [7:0] SE            = 8'd240;
   localparam logic [7:0] OPT_ECHO      = 8'd1;
   localparam logic [7:0] OPT_SGA       = 8'd3;
   localparam logic [7:0] OPT_TERM_TYPE = 8'd24;
   localparam logic [7:0] OPT_WIN_SIZE  = 8'd31;
   localparam logic [7:0] TERM_IS       = 8'd0;

   localparam logic [15:0] DIM_LIMIT = 16'd1000;

   // sizing
   localparam int SUB_DEPTH_DEF = 64;
   localparam int TERM_DEPTH    = 32;
   localparam int MAX_RESULTS   = 32;
   localparam int TTYPE_MAX     = (TERM_DEPTH - 1 < MAX_RESULTS - 1) ?
                                  TERM_DEPTH - 1 : MAX_RESULTS - 1;
   localparam int TTYPE_CNT_W   = 5;
   localparam int NAWS_LEN      = 5;
   localparam int QUEUE_DEPTH   = 2;

   // result kinds
   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_REPLY = 2'd1;
   localparam logic [1:0] KIND_TTYPE = 2'd2;
   localparam logic [1:0] KIND_CHUNK = 2'd3;

   // back-end operations
   localparam logic [2:0] OP_NOP       = 3'd0;
   localparam logic [2:0] OP_DATA      = 3'd1;
   localparam logic [2:0] OP_REPLY     = 3'd2;
   localparam logic [2:0] OP_SUB_CLEAR = 3'd3;
   localparam logic [2:0] OP_SUB_STORE = 3'd4;
   localparam logic [2:0] OP_SUB_DONE  = 3'd5;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] verb;
      logic [7:0] value;
      logic       chunk_end;
   } cmd_type;

endpackage

`default_nettype wire

// ===== rtl/core/trp_channel_if.sv =====
// ----------------------------------------------------------------------------
// trp channel interfaces
// valid/ready channels for received bytes and parser results
// ----------------------------------------------------------------------------
`default_nettype none

interface trp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       chunk_end;

   modport source (output valid, output byte_in, output chunk_end, input ready);
   modport sink   (input valid, input byte_in, input chunk_end, output ready);
endinterface

interface trp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  value;
   logic        last;
   logic [9:0]  columns;
   logic [9:0]  rows_now;
   logic [15:0] chunk_count;

   modport source (output valid, output kind, output value, output last,
                   output columns, output rows_now, output chunk_count, input ready);
   modport sink   (input valid, input kind, input value, input last,
                   input columns, input rows_now, input chunk_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/telnet_receive_parser_core.sv =====
// ----------------------------------------------------------------------------
// telnet_receive_parser_core
// receive-side telnet parser and option negotiator
// ----------------------------------------------------------------------------
// req: one received byte per transfer, chunk_end flags the last byte of a
//   host chunk. rsp: one result per transfer (data, reply to peer, terminal
//   type byte or chunk end); last marks the final result of an input byte.
// path: a byte's command is written into the command queue, and the engine
//   registers each of its results in the output register. the engine emits
//   one result per cycle while rsp.ready is high, so a DO/WILL answer gives
//   IAC, verb and option, a terminal type message one result per type byte,
//   and a chunk end one more. a two-entry command queue lets the classifier
//   run ahead of the engine; req.ready drops only when that queue is full.
// reset: parser to data state, window 80x24, chunk count zero, queue and
//   output register emptied.
// stalls: with rsp.ready low the output register holds its result, the
//   engine waits, the queue fills and req.ready goes low.
// ----------------------------------------------------------------------------
`default_nettype none

module telnet_receive_parser_core #(
   parameter int SUB_DEPTH = trp_pkg::SUB_DEPTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   trp_req_if.sink   req,
   trp_rsp_if.source rsp
);

   // classifier to engine command path
   logic             q_push;
   logic             q_full;
   trp_pkg::cmd_type q_push_cmd;
   logic             q_valid;
   logic             q_pop;
   trp_pkg::cmd_type q_head;

   // front: parse state and command classification
   trp_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .q_full (q_full),
      .q_push (q_push),
      .q_cmd  (q_push_cmd)
   );

   // short queue decoupling both halves
   trp_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .head     (q_head)
   );

   // back: result generation, buffer and window state
   trp_back #(
      .SUB_DEPTH (SUB_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd       (q_head),
      .cmd_pop   (q_pop),
      .rsp       (rsp)
   );

endmodule

`default_nettype wire

// ===== rtl/core/trp_front.sv =====
// ----------------------------------------------------------------------------
// trp_front
// telnet byte classifier: tracks IAC sequences and issues back-end commands
// ----------------------------------------------------------------------------
`default_nettype none

module trp_front (
   input  wire logic          clock,
   input  wire logic          reset,
   trp_req_if.sink            req,
   input  wire logic          q_full,
   output logic               q_push,
   output trp_pkg::cmd_type   q_cmd
);

   localparam logic [2:0] PS_DATA    = 3'd0;
   localparam logic [2:0] PS_IAC     = 3'd1;
   localparam logic [2:0] PS_CMD     = 3'd2;
   localparam logic [2:0] PS_SUB     = 3'd3;
   localparam logic [2:0] PS_SUB_IAC = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [7:0] pending_ff, pending_in;
   logic [7:0] b;

   assign req.ready = !q_full;
   assign q_push    = req.valid && !q_full;
   assign b         = req.byte_in;

   always_comb begin
      state_in          = state_ff;
      pending_in        = pending_ff;
      q_cmd.op          = trp_pkg::OP_NOP;
      q_cmd.verb        = trp_pkg::WONT;
      q_cmd.value       = b;
      q_cmd.chunk_end   = req.chunk_end;
      case (state_ff)
         PS_DATA: begin
            if (b == trp_pkg::IAC) begin
               state_in = PS_IAC;
            end else begin
               q_cmd.op = trp_pkg::OP_DATA;
            end
         end
         PS_IAC: begin
            if (b == trp_pkg::IAC) begin
               q_cmd.op = trp_pkg::OP_DATA;
               state_in = PS_DATA;
            end else if (b inside {trp_pkg::DO, trp_pkg::DONT,
                                   trp_pkg::WILL, trp_pkg::WONT}) begin
               pending_in = b;
               state_in   = PS_CMD;
            end else if (b == trp_pkg::SB) begin
               q_cmd.op = trp_pkg::OP_SUB_CLEAR;
               state_in = PS_SUB;
            end else begin
               state_in = PS_DATA;
            end
         end
         PS_CMD: begin
            // byte is the option, whatever its value
            if (pending_ff == trp_pkg::DO) begin
               q_cmd.op   = trp_pkg::OP_REPLY;
               q_cmd.verb = (b inside {trp_pkg::OPT_ECHO, trp_pkg::OPT_SGA}) ?
                            trp_pkg::WILL : trp_pkg::WONT;
            end else if (pending_ff == trp_pkg::WILL) begin
               q_cmd.op   = trp_pkg::OP_REPLY;
               q_cmd.verb = (b inside {trp_pkg::OPT_SGA, trp_pkg::OPT_WIN_SIZE,
                                       trp_pkg::OPT_TERM_TYPE}) ?
                            trp_pkg::DO : trp_pkg::DONT;
            end
            state_in = PS_DATA;
         end
         PS_SUB: begin
            if (b == trp_pkg::IAC) begin
               state_in = PS_SUB_IAC;
            end else begin
               q_cmd.op = trp_pkg::OP_SUB_STORE;
            end
         end
         PS_SUB_IAC: begin
            if (b == trp_pkg::SE) begin
               q_cmd.op = trp_pkg::OP_SUB_DONE;
               state_in = PS_DATA;
            end else begin
               if (b == trp_pkg::IAC) begin
                  q_cmd.op = trp_pkg::OP_SUB_STORE;
               end
               state_in = PS_SUB;
            end
         end
         default: begin
            state_in = PS_DATA;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= PS_DATA;
         pending_ff <= '0;
      end else if (q_push) begin
         state_ff   <= state_in;
         pending_ff <= pending_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/trp_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// trp_cmd_queue
// short command fifo between the classifier and the result engine
// ----------------------------------------------------------------------------
`default_nettype none

module trp_cmd_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire trp_pkg::cmd_type  push_cmd,
   output logic                   full,
   input  wire logic              pop,
   output logic                   valid,
   output trp_pkg::cmd_type       head
);

   localparam int DEPTH = trp_pkg::QUEUE_DEPTH;
   localparam int QW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   trp_pkg::cmd_type entry_ff [DEPTH];
   logic [QW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [QW:0]      count_ff;

   assign full  = (count_ff == (QW+1)'(DEPTH));
   assign valid = (count_ff != '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/trp_back.sv =====
// ----------------------------------------------------------------------------
// trp_back
// result engine: data, replies, subnegotiation buffer, window size, chunk ends
// ----------------------------------------------------------------------------
`default_nettype none
`include "telnet_receive_parser_core_defines.svh"

module trp_back #(
   parameter int SUB_DEPTH = trp_pkg::SUB_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   input  wire trp_pkg::cmd_type  cmd,
   output logic                   cmd_pop,
   trp_rsp_if.source              rsp
);

   localparam int PW = $clog2(SUB_DEPTH + 1);
   localparam int AW = $clog2(SUB_DEPTH);
   localparam int CW = trp_pkg::TTYPE_CNT_W;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_REPLY = 2'd1;
   localparam logic [1:0] ST_TTYPE = 2'd2;
   localparam logic [1:0] ST_CHUNK = 2'd3;

   logic [1:0]    st_ff, st_in;
   logic [7:0]    verb_ff, verb_in;
   logic [7:0]    opt_ff, opt_in;
   logic          end_ff, end_in;
   logic          step_ff, step_in;
   logic [CW-1:0] left_ff, left_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [7:0]    rd_data_ff;
   logic [PW-1:0] sub_len_ff, sub_len_in;
   logic [7:0]    head_ff [trp_pkg::NAWS_LEN];
   logic [9:0]    cols_ff, cols_in;
   logic [9:0]    rows_ff, rows_in;
   logic [15:0]   cnt_ff, cnt_in;

   logic          ovalid_ff;
   logic [1:0]    okind_ff;
   logic [7:0]    ovalue_ff;
   logic          olast_ff;
   logic [9:0]    ocols_ff, orows_ff;
   logic [15:0]   ocount_ff;

   logic [7:0]    sub_mem [SUB_DEPTH];
   logic          mem_we;
   logic          head_we;

   logic          out_free;
   logic          emit;
   logic [1:0]    e_kind;
   logic [7:0]    e_value;
   logic          e_last;
   logic [15:0]   e_count;

   logic [15:0]   naws_w, naws_h;
   logic [8:0]    tail_len;
   logic          naws_ok, ttype_ok;
   logic [CW-1:0] term_n;

   assign out_free = !ovalid_ff || rsp.ready;
   assign cmd_pop  = cmd_valid && (st_ff == ST_IDLE) && out_free;

   assign naws_w   = {head_ff[1], head_ff[2]};
   assign naws_h   = {head_ff[3], head_ff[4]};
   assign naws_ok  = (sub_len_ff >= PW'(trp_pkg::NAWS_LEN)) &&
                     (head_ff[0] == trp_pkg::OPT_WIN_SIZE);
   assign ttype_ok = (sub_len_ff >= PW'(3)) && (head_ff[0] == trp_pkg::OPT_TERM_TYPE) &&
                     (head_ff[1] == trp_pkg::TERM_IS);
   assign tail_len = 9'(sub_len_ff) - 9'd2;
   assign term_n   = (tail_len > 9'(trp_pkg::TTYPE_MAX)) ? CW'(trp_pkg::TTYPE_MAX)
                                                         : tail_len[CW-1:0];

   always_comb begin
      st_in      = st_ff;
      verb_in    = verb_ff;
      opt_in     = opt_ff;
      end_in     = end_ff;
      step_in    = step_ff;
      left_in    = left_ff;
      rd_ptr_in  = rd_ptr_ff;
      sub_len_in = sub_len_ff;
      cols_in    = cols_ff;
      rows_in    = rows_ff;
      cnt_in     = cnt_ff;
      mem_we     = 1'b0;
      head_we    = 1'b0;
      emit       = 1'b0;
      e_kind     = trp_pkg::KIND_DATA;
      e_value    = '0;
      e_last     = 1'b0;
      e_count    = '0;
      case (st_ff)
         ST_IDLE: begin
            if (cmd_pop) begin
               case (cmd.op)
                  trp_pkg::OP_DATA: begin
                     emit    = 1'b1;
                     e_value = cmd.value;
                     e_last  = !cmd.chunk_end;
                     cnt_in  = (cnt_ff == '1) ? cnt_ff : cnt_ff + 16'd1;
                     if (cmd.chunk_end) begin
                        st_in = ST_CHUNK;
                     end
                  end
                  trp_pkg::OP_REPLY: begin
                     emit    = 1'b1;
                     e_kind  = trp_pkg::KIND_REPLY;
                     e_value = trp_pkg::IAC;
                     verb_in = cmd.verb;
                     opt_in  = cmd.value;
                     end_in  = cmd.chunk_end;
                     step_in = 1'b0;
                     st_in   = ST_REPLY;
                  end
                  default: begin
                     if (cmd.op == trp_pkg::OP_SUB_CLEAR) begin
                        sub_len_in = '0;
                     end
                     if (cmd.op == trp_pkg::OP_SUB_STORE &&
                         sub_len_ff < PW'(SUB_DEPTH)) begin
                        mem_we     = 1'b1;
                        head_we    = (sub_len_ff < PW'(trp_pkg::NAWS_LEN));
                        sub_len_in = sub_len_ff + 1'b1;
                     end
                     if (cmd.op == trp_pkg::OP_SUB_DONE && naws_ok) begin
                        if (naws_w != '0 && naws_w < trp_pkg::DIM_LIMIT) begin
                           cols_in = naws_w[9:0];
                        end
                        if (naws_h != '0 && naws_h < trp_pkg::DIM_LIMIT) begin
                           rows_in = naws_h[9:0];
                        end
                     end
                     if (cmd.op == trp_pkg::OP_SUB_DONE && ttype_ok) begin
                        // stream the type name out of the buffer
                        left_in   = term_n;
                        rd_ptr_in = PW'(2);
                        end_in    = cmd.chunk_end;
                        st_in     = ST_TTYPE;
                     end else if (cmd.chunk_end) begin
                        emit    = 1'b1;
                        e_kind  = trp_pkg::KIND_CHUNK;
                        e_last  = 1'b1;
                        e_count = cnt_ff;
                        cnt_in  = '0;
                     end
                  end
               endcase
            end
         end
         ST_REPLY: begin
            if (out_free) begin
               emit    = 1'b1;
               e_kind  = trp_pkg::KIND_REPLY;
               e_value = step_ff ? opt_ff : verb_ff;
               e_last  = step_ff && !end_ff;
               step_in = 1'b1;
               if (step_ff) begin
                  st_in = end_ff ? ST_CHUNK : ST_IDLE;
               end
            end
         end
         ST_TTYPE: begin
            if (out_free) begin
               emit      = 1'b1;
               e_kind    = trp_pkg::KIND_TTYPE;
               e_value   = rd_data_ff;
               e_last    = (left_ff == CW'(1)) && !end_ff;
               left_in   = left_ff - 1'b1;
               rd_ptr_in = rd_ptr_ff + 1'b1;
               if (left_ff == CW'(1)) begin
                  st_in = end_ff ? ST_CHUNK : ST_IDLE;
               end
            end
         end
         ST_CHUNK: begin
            if (out_free) begin
               emit    = 1'b1;
               e_kind  = trp_pkg::KIND_CHUNK;
               e_last  = 1'b1;
               e_count = cnt_ff;
               cnt_in  = '0;
               st_in   = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= ST_IDLE;
         sub_len_ff <= '0;
         cols_ff    <= 10'd80;
         rows_ff    <= 10'd24;
         cnt_ff     <= '0;
         ovalid_ff  <= 1'b0;
         left_ff    <= '0;
      end else begin
         st_ff      <= st_in;
         sub_len_ff <= sub_len_in;
         cols_ff    <= cols_in;
         rows_ff    <= rows_in;
         cnt_ff     <= cnt_in;
         left_ff    <= left_in;
         if (out_free) begin
            ovalid_ff <= emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      verb_ff   <= verb_in;
      opt_ff    <= opt_in;
      end_ff    <= end_in;
      step_ff   <= step_in;
      rd_ptr_ff <= rd_ptr_in;
      if (out_free && emit) begin
         okind_ff  <= e_kind;
         ovalue_ff <= e_value;
         olast_ff  <= e_last;
         ocols_ff  <= cols_in;
         orows_ff  <= rows_in;
         ocount_ff <= e_count;
      end
      if (head_we) begin
         head_ff[sub_len_ff[2:0]] <= cmd.value;
      end
   end

   // subnegotiation buffer, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         sub_mem[sub_len_ff[AW-1:0]] <= cmd.value;
      end
      rd_data_ff <= sub_mem[rd_ptr_in[AW-1:0]];
   end

   assign rsp.valid       = ovalid_ff;
   assign rsp.kind        = okind_ff;
   assign rsp.value       = ovalue_ff;
   assign rsp.last        = olast_ff;
   assign rsp.columns     = ocols_ff;
   assign rsp.rows_now    = orows_ff;
   assign rsp.chunk_count = ocount_ff;

   `TRP_ASSERT_NEXT(a_reply_enters_seq, clock, reset,
      cmd_pop && cmd.op == trp_pkg::OP_REPLY, st_ff == ST_REPLY)
   `TRP_ASSERT_IMPLY(a_ttype_count_live, clock, reset,
      st_ff == ST_TTYPE, left_ff != '0)
   `TRP_ASSERT_IMPLY(a_chunk_is_last, clock, reset,
      ovalid_ff && okind_ff == trp_pkg::KIND_CHUNK, olast_ff)
   `TRP_ASSERT_IMPLY(a_sub_len_bound, clock, reset,
      1'b1, sub_len_ff <= PW'(SUB_DEPTH))

endmodule

`default_nettype wire
